// File: design/tpe_pkg.sv
`timescale 1ns / 1ps
// Package for the timer pool engine: command and result structs,
// action codes, slot and sequencer state types, sizing constants.
// No dependencies.
package tpe_pkg;

  localparam int TPE_TIMER_SLOTS = 8;
  localparam int TPE_MAX_RESULTS = 8;
  localparam int TPE_RES_CNT_W   = 4;
  localparam int TPE_RES_IDX_W   = 3;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_START  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_RESET  = 3'd4,
    ACT_POLL   = 3'd5
  } tpe_action_t;

  typedef enum logic [1:0] {
    SLOT_STOPPED = 2'd0,
    SLOT_RUNNING = 2'd1,
    SLOT_EXPIRED = 2'd2
  } tpe_slot_state_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SWEEP = 2'd1,
    FSM_EMIT  = 2'd2
  } tpe_fsm_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  target_timer;
    logic [31:0] period;
    logic        periodic;
  } tpe_cmd_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        fired;
    logic        running;
    logic [31:0] tick_now;
    logic        last;
  } tpe_rsp_t;

endpackage

// File: design/tpe_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module tpe_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/timer_pool_engine.sv
`timescale 1ns / 1ps
// Timer pool engine top level: command sequencer, slot sweep and result drain.
// Depends on tpe_pkg and tpe_ram.
//
// A bank of TIMER_SLOTS timer slots driven by one command at a time. Each
// command (tick, create, start, stop, reset count, poll) walks every slot once
// through a single shared update unit, one slot per cycle, with the elapsed
// and period values held in two small RAMs read one slot ahead. A command
// therefore holds the block through accept, the sweep and the read latency,
// then through its results, which wait while rsp_stall is high (a poll gives
// one result per expired slot, up to eight, else a single result); cmd_stall
// stays high until the last result transfers.
// The running flag of every result reflects the target slot after the sweep.
module timer_pool_engine
  import tpe_pkg::*;
#(
  parameter int TIMER_SLOTS = TPE_TIMER_SLOTS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  tpe_cmd_t cmd,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output tpe_rsp_t rsp
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int HIT_W = (IDX_W > 4) ? IDX_W : 4;

  tpe_fsm_t state, state_next;

  tpe_cmd_t               cmd_reg;
  logic [31:0]            tick_count;
  logic [CNT_W-1:0]       idx;
  logic                   proc_valid;
  logic [IDX_W-1:0]       proc_idx;
  tpe_slot_state_t        slot_state [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] in_use;
  logic [TIMER_SLOTS-1:0] reload;
  logic                   claimed;
  logic [3:0]             res_slot;
  logic [TPE_RES_CNT_W-1:0] fire_cnt;
  logic [3:0]             fire_q [TPE_MAX_RESULTS];
  logic                   run_flag;
  logic [TPE_RES_IDX_W-1:0] emit_ptr;

  logic cmd_take;
  logic rsp_take;
  logic sweep_on;
  logic sweep_end;
  logic rsp_last;
  logic polled;
  logic [TPE_RES_CNT_W-1:0] res_total;

  logic [31:0]     elapsed_rd;
  logic [31:0]     period_rd;
  logic [31:0]     elapsed_inc;
  tpe_slot_state_t cur_st;
  tpe_slot_state_t new_st;
  logic            cur_use;
  logic            cur_rel;
  logic            new_use;
  logic            new_rel;
  logic            hit;
  logic            el_we;
  logic [31:0]     el_wd;
  logic            pe_we;
  logic            claim;
  logic            fire;

  tpe_ram #(
    .WIDTH (32),
    .DEPTH (TIMER_SLOTS),
    .ADDR_W(IDX_W)
  ) u_elapsed_ram (
    .clk  (clk),
    .we   (el_we),
    .waddr(proc_idx),
    .wdata(el_wd),
    .raddr(idx[IDX_W-1:0]),
    .rdata(elapsed_rd)
  );

  tpe_ram #(
    .WIDTH (32),
    .DEPTH (TIMER_SLOTS),
    .ADDR_W(IDX_W)
  ) u_period_ram (
    .clk  (clk),
    .we   (pe_we),
    .waddr(proc_idx),
    .wdata(cmd_reg.period),
    .raddr(idx[IDX_W-1:0]),
    .rdata(period_rd)
  );

  assign sweep_end = (idx == CNT_W'(TIMER_SLOTS));
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;
  assign polled    = (cmd_reg.action == ACT_POLL) && (fire_cnt != '0);
  assign res_total = polled ? fire_cnt : TPE_RES_CNT_W'(1);
  assign rsp_last  = (TPE_RES_CNT_W'({1'b0, emit_ptr}) + TPE_RES_CNT_W'(1)) == res_total;

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (cmd_valid) begin
          state_next = FSM_SWEEP;
        end
      end
      FSM_SWEEP: begin
        if (sweep_end) begin
          state_next = FSM_EMIT;
        end
      end
      FSM_EMIT: begin
        if (rsp_take && rsp_last) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = (state != FSM_IDLE);
    rsp_valid = (state == FSM_EMIT);
    sweep_on  = (state == FSM_SWEEP);
  end

  always_comb begin
    rsp.slot     = polled ? fire_q[emit_ptr] : res_slot;
    rsp.fired    = polled;
    rsp.running  = run_flag;
    rsp.tick_now = tick_count;
    rsp.last     = rsp_last;
  end

  // per-slot update unit
  always_comb begin
    cur_st      = slot_state[proc_idx];
    cur_use     = in_use[proc_idx];
    cur_rel     = reload[proc_idx];
    elapsed_inc = elapsed_rd + 32'd1;
    hit         = HIT_W'(cmd_reg.target_timer) == HIT_W'(proc_idx);
    new_st      = cur_st;
    new_use     = cur_use;
    new_rel     = cur_rel;
    el_we       = 1'b0;
    el_wd       = '0;
    pe_we       = 1'b0;
    claim       = 1'b0;
    fire        = 1'b0;
    if (proc_valid) begin
      case (cmd_reg.action)
        ACT_TICK: begin
          if (cur_st == SLOT_RUNNING) begin
            el_we = 1'b1;
            el_wd = elapsed_inc;
            if (elapsed_inc >= period_rd) begin
              new_st = SLOT_EXPIRED;
            end
          end
        end
        ACT_CREATE: begin
          if (!claimed && (cmd_reg.period != '0) && !cur_use) begin
            new_use = 1'b1;
            new_st  = SLOT_STOPPED;
            new_rel = cmd_reg.periodic;
            el_we   = 1'b1;
            pe_we   = 1'b1;
            claim   = 1'b1;
          end
        end
        ACT_START: begin
          if (hit && cur_use) begin
            el_we  = 1'b1;
            new_st = SLOT_RUNNING;
          end
        end
        ACT_STOP: begin
          if (hit) begin
            new_st = SLOT_STOPPED;
          end
        end
        ACT_RESET: begin
          if (hit) begin
            el_we = 1'b1;
          end
        end
        ACT_POLL: begin
          if ((cur_st == SLOT_EXPIRED) && (fire_cnt != TPE_RES_CNT_W'(TPE_MAX_RESULTS))) begin
            fire = 1'b1;
            if (cur_rel) begin
              el_we  = 1'b1;
              new_st = SLOT_RUNNING;
            end else begin
              new_st = SLOT_STOPPED;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FSM_IDLE;
      tick_count <= '0;
      idx        <= '0;
      proc_valid <= 1'b0;
      proc_idx   <= '0;
      in_use     <= '0;
      reload     <= '0;
      claimed    <= 1'b0;
      res_slot   <= 4'(TIMER_SLOTS);
      fire_cnt   <= '0;
      run_flag   <= 1'b0;
      emit_ptr   <= '0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        slot_state[i] <= SLOT_STOPPED;
      end
    end else begin
      state      <= state_next;
      proc_valid <= sweep_on && !sweep_end;
      proc_idx   <= idx[IDX_W-1:0];
      if (cmd_take) begin
        cmd_reg  <= cmd;
        idx      <= '0;
        claimed  <= 1'b0;
        res_slot <= 4'(TIMER_SLOTS);
        fire_cnt <= '0;
        run_flag <= 1'b0;
        emit_ptr <= '0;
        if (cmd.action == ACT_TICK) begin
          tick_count <= tick_count + 32'd1;
        end
      end else if (sweep_on && !sweep_end) begin
        idx <= idx + CNT_W'(1);
      end
      if (proc_valid) begin
        slot_state[proc_idx] <= new_st;
        in_use[proc_idx]     <= new_use;
        reload[proc_idx]     <= new_rel;
        if (claim) begin
          claimed  <= 1'b1;
          res_slot <= 4'(proc_idx);
        end
        if (fire) begin
          fire_q[fire_cnt[TPE_RES_IDX_W-1:0]] <= 4'(proc_idx);
          fire_cnt <= fire_cnt + TPE_RES_CNT_W'(1);
        end
        if (hit) begin
          run_flag <= (new_st == SLOT_RUNNING);
        end
      end
      if (rsp_take && !rsp_last) begin
        emit_ptr <= emit_ptr + TPE_RES_IDX_W'(1);
      end
    end
  end

endmodule

// File: test/timer_pool_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for timer_pool_engine: directed and random command
// streams with random idling on both channels, checked against a slot-level predictor.
// Depends on tpe_pkg and the timer_pool_engine RTL.
module timer_pool_engine_test;
  import tpe_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [3:0] NO_SLOT = 4'(TPE_TIMER_SLOTS);
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_TAIL = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 2 * TPE_TIMER_SLOTS + 8;

  typedef struct packed {
    tpe_cmd_t cmd;
    logic     wait_drain;
  } queued_cmd_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  tpe_cmd_t cmd = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  tpe_rsp_t rsp;

  queued_cmd_t cmd_backlog[$];
  tpe_rsp_t    timer_results_due[$];
  tpe_rsp_t    step_rsps[$];
  tpe_rsp_t    want;

  tpe_slot_state_t slot_phase[TPE_TIMER_SLOTS];
  logic [31:0]     slot_count[TPE_TIMER_SLOTS];
  logic [31:0]     slot_period[TPE_TIMER_SLOTS];
  logic            slot_periodic[TPE_TIMER_SLOTS];
  logic            slot_taken[TPE_TIMER_SLOTS];
  logic [31:0]     tick_total;

  bit cmd_taken = 1'b0;
  bit rsp_taken = 1'b0;
  bit drain_next = 1'b0;
  int cmd_gap = 0;
  int rsp_gap = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;

  timer_pool_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  function automatic void log_rsp(input logic [3:0] s, input logic f);
    tpe_rsp_t r;
    r = '0;
    r.slot = s;
    r.fired = f;
    step_rsps.push_back(r);
  endfunction

  function automatic string rsp_text(input tpe_rsp_t r);
    return $sformatf("slot=%0d fired=%0d running=%0d tick=%0d last=%0d",
                     r.slot, r.fired, r.running, r.tick_now, r.last);
  endfunction

  task automatic predict_timer_results(input tpe_cmd_t c);
    logic [3:0] tgt;
    logic       tgt_ok;
    logic       run_now;
    logic [3:0] made;
    tpe_rsp_t   r;
    int         i;
    tgt = c.target_timer;
    tgt_ok = (tgt < TPE_TIMER_SLOTS);
    step_rsps.delete();
    case (c.action)
      ACT_TICK: begin
        tick_total = tick_total + 32'd1;
        for (i = 0; i < TPE_TIMER_SLOTS; i++) begin
          if (slot_phase[i] == SLOT_RUNNING) begin
            slot_count[i] = slot_count[i] + 32'd1;
            if (slot_count[i] >= slot_period[i]) slot_phase[i] = SLOT_EXPIRED;
          end
        end
        log_rsp(NO_SLOT, 1'b0);
      end
      ACT_CREATE: begin
        made = NO_SLOT;
        if (c.period != 32'd0) begin
          for (i = 0; i < TPE_TIMER_SLOTS; i++) begin
            if (!slot_taken[i] && made == NO_SLOT) begin
              slot_taken[i] = 1'b1;
              slot_phase[i] = SLOT_STOPPED;
              slot_periodic[i] = c.periodic;
              slot_count[i] = 32'd0;
              slot_period[i] = c.period;
              made = 4'(i);
            end
          end
        end
        log_rsp(made, 1'b0);
      end
      ACT_START: begin
        if (tgt_ok && slot_taken[tgt]) begin
          slot_count[tgt] = 32'd0;
          slot_phase[tgt] = SLOT_RUNNING;
        end
        log_rsp(NO_SLOT, 1'b0);
      end
      ACT_STOP: begin
        if (tgt_ok) slot_phase[tgt] = SLOT_STOPPED;
        log_rsp(NO_SLOT, 1'b0);
      end
      ACT_RESET: begin
        if (tgt_ok) slot_count[tgt] = 32'd0;
        log_rsp(NO_SLOT, 1'b0);
      end
      ACT_POLL: begin
        for (i = 0; i < TPE_TIMER_SLOTS; i++) begin
          if (step_rsps.size() < TPE_MAX_RESULTS && slot_phase[i] == SLOT_EXPIRED) begin
            if (slot_periodic[i]) begin
              slot_count[i] = 32'd0;
              slot_phase[i] = SLOT_RUNNING;
            end else begin
              slot_phase[i] = SLOT_STOPPED;
            end
            log_rsp(4'(i), 1'b1);
          end
        end
        if (step_rsps.size() == 0) log_rsp(NO_SLOT, 1'b0);
      end
      default: begin
        log_rsp(NO_SLOT, 1'b0);
      end
    endcase
    run_now = tgt_ok ? (slot_phase[tgt] == SLOT_RUNNING) : 1'b0;
    for (i = 0; i < step_rsps.size(); i++) begin
      r = step_rsps[i];
      r.running = run_now;
      r.tick_now = tick_total;
      r.last = (i == step_rsps.size() - 1);
      timer_results_due.push_back(r);
    end
  endtask

  task automatic add_cmd(input logic [2:0] act, input logic [3:0] tgt,
                         input logic [31:0] per, input logic ar);
    queued_cmd_t q;
    q.cmd.action = act;
    q.cmd.target_timer = tgt;
    q.cmd.period = per;
    q.cmd.periodic = ar;
    q.wait_drain = drain_next;
    drain_next = 1'b0;
    cmd_backlog.push_back(q);
  endtask

  // Drive commands and response stall.
  always @(negedge clk) begin
    if (!rst) begin
      if (!cmd_valid || cmd_taken) begin
        if (cmd_gap == 0 && cmd_backlog.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
          cmd_gap = $urandom_range(1, 6);
        if (cmd_gap != 0) begin
          cmd_gap = cmd_gap - 1;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].wait_drain && timer_results_due.size() != 0)) begin
          cmd <= cmd_backlog[0].cmd;
          cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
      if (rsp_gap == 0 && cmd_backlog.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
        rsp_gap = $urandom_range(1, 6);
      if (rsp_gap != 0) begin
        rsp_gap = rsp_gap - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Sample transfers, predict and check.
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken = 1'b0;
      rsp_taken = 1'b0;
    end else begin
      cmd_taken = cmd_valid && !cmd_stall;
      rsp_taken = rsp_valid && !rsp_stall;
      if (cmd_taken) predict_timer_results(cmd);
      if (rsp_taken) begin
        if (timer_results_due.size() == 0) begin
          $display("%0t: unexpected result expected none actual %s", $time, rsp_text(rsp));
          mismatch_count++;
        end else begin
          want = timer_results_due.pop_front();
          if (rsp !== want) begin
            $display("%0t: mismatch expected %s actual %s",
                     $time, rsp_text(want), rsp_text(rsp));
            mismatch_count++;
          end
        end
      end
      if (cmd_taken || rsp_taken) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    int  kind;
    int  n;
    int  sel;
    bit  mid_drain_done;
    bit  timed_out;
    logic [31:0] per;
    mid_drain_done = 1'b0;
    tick_total = 32'd0;
    for (int i = 0; i < TPE_TIMER_SLOTS; i++) begin
      slot_phase[i] = SLOT_STOPPED;
      slot_count[i] = 32'd0;
      slot_period[i] = 32'd0;
      slot_periodic[i] = 1'b0;
      slot_taken[i] = 1'b0;
    end

    add_cmd(ACT_POLL, 4'd0, 32'd0, 1'b0);
    add_cmd(ACT_CREATE, 4'd0, 32'd0, 1'b1);
    add_cmd(ACT_CREATE, 4'd15, 32'd1, 1'b0);
    add_cmd(ACT_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b1);
    add_cmd(ACT_CREATE, 4'd7, 32'd2, 1'b1);
    add_cmd(ACT_START, 4'd0, 32'hFFFF_FFFF, 1'b1);
    add_cmd(ACT_START, 4'd1, 32'd0, 1'b0);
    add_cmd(ACT_START, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_START, 4'd5, 32'd0, 1'b0);
    add_cmd(ACT_START, 4'd15, 32'd0, 1'b1);
    add_cmd(ACT_TICK, 4'd0, 32'd0, 1'b0);
    add_cmd(ACT_POLL, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_TICK, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_START, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_TICK, 4'd1, 32'd0, 1'b0);
    add_cmd(ACT_TICK, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_POLL, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_TICK, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_TICK, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_STOP, 4'd2, 32'd0, 1'b0);
    add_cmd(ACT_POLL, 4'd1, 32'd0, 1'b0);
    add_cmd(ACT_RESET, 4'd1, 32'd0, 1'b0);
    add_cmd(ACT_RESET, 4'd12, 32'd0, 1'b0);
    add_cmd(ACT_STOP, 4'd3, 32'd0, 1'b0);
    add_cmd(ACT_SPARE_LO, 4'd1, 32'hFFFF_FFFF, 1'b1);
    add_cmd(ACT_SPARE_HI, 4'd8, 32'd0, 1'b0);

    drain_next = 1'b1;
    while (cmd_backlog.size() < RANDOM_ITEMS) begin
      if (!mid_drain_done && cmd_backlog.size() >= RANDOM_ITEMS / 2) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          sel = $urandom_range(0, 9);
          if (sel < 7) per = $urandom_range(1, 6);
          else if (sel < 9) per = $urandom;
          else per = 32'hFFFF_FFFF;
          add_cmd(ACT_CREATE, 4'($urandom_range(0, 15)), per, 1'($urandom_range(0, 1)));
        end
        n = $urandom_range(1, 4);
        repeat (n) add_cmd(ACT_START, 4'($urandom_range(0, 7)), $urandom,
                           1'($urandom_range(0, 1)));
        n = $urandom_range(1, 6);
        repeat (n) add_cmd(ACT_TICK, 4'($urandom_range(0, 15)), $urandom,
                           1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          add_cmd($urandom_range(0, 1) ? ACT_STOP : ACT_RESET, 4'($urandom_range(0, 8)),
                  $urandom, 1'($urandom_range(0, 1)));
        add_cmd(ACT_POLL, 4'($urandom_range(0, 8)), $urandom, 1'($urandom_range(0, 1)));
      end else begin
        add_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), $urandom,
                1'($urandom_range(0, 1)));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while ((cmd_backlog.size() != 0 || cmd_valid || timer_results_due.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles < WATCHDOG_LIMIT) repeat (SETTLE_CYCLES) @(posedge clk);
    timed_out = (idle_cycles >= WATCHDOG_LIMIT);
    if (timed_out) $display("%0t: watchdog expired with no transfer", $time);
    if (timer_results_due.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, timer_results_due.size());
    if (!timed_out && mismatch_count == 0 && timer_results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: timer_pool_engine.f
design/tpe_pkg.sv
design/tpe_ram.sv
design/timer_pool_engine.sv
test/timer_pool_engine_test.sv
